// ===== rtl/bmp_pixel_row_unpacker_macros.svh =====
// Assertion macros for the bitmap pixel row unpacker.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef BMP_PIXEL_ROW_UNPACKER_MACROS_SVH
`define BMP_PIXEL_ROW_UNPACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BPU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpu check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpu check failed");

`else

`define BPU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define BPU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bpu_pkg.sv =====
// Shared types and constants of the bitmap pixel row unpacker.
// No dependencies; imported by the top level.
package bpu_pkg;

    localparam int CFG_DIM_W    = 13;
    localparam int PAL_COUNT_W  = 9;
    localparam int COORD_W      = 12;
    localparam int COLOR_W      = 8;
    localparam int RGB_W        = 3 * COLOR_W;
    localparam int ROW_BITS_W   = 18;
    localparam int ROW_BYTES_W  = 15;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 3;

    localparam int MAX_DIMENSION_DEFAULT   = 4096;
    localparam int PALETTE_ENTRIES_DEFAULT = 256;

    // Pixel formats
    localparam logic [1:0] FMT_1BPP  = 2'd0;
    localparam logic [1:0] FMT_4BPP  = 2'd1;
    localparam logic [1:0] FMT_8BPP  = 2'd2;
    localparam logic [1:0] FMT_24BPP = 2'd3;

    // Request operations
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_WIDTH    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_HEIGHT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd5;

    localparam logic [CFG_DIM_W-1:0] IMAGE_DIM_RESET = 13'd1;
    localparam logic [CFG_DIM_W-1:0] CLIP_DIM_RESET  = 13'd4096;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [RGB_W-1:0]   rgb;
        logic               from_palette;
        logic               visible;
        logic               last_of_run;
        logic               image_end;
    } t_pix_meta;

    // Zero counts as one, values above the limit saturate.
    function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                       input int unsigned max_dim);
        logic [CFG_DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            r = CFG_DIM_W'(max_dim);
        end
        return r;
    endfunction

endpackage

// ===== rtl/bpu_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address collision. No dependencies.
module bpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data when no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bmp_pixel_row_unpacker.sv =====
// Top level of the bitmap pixel row unpacker: APB registers, byte unpacker,
// palette RAM and output register. Depends on bpu_pkg, bpu_ram and the macro header.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | sink      | i_in_valid / o_in_stall | operation, data byte, palette entry
//   out     | source    | o_out_valid/i_out_stall | column, row, rgb, visible, flags
//   apb     | slave     | psel/penable, pready=1  | registers at byte address 4*index
//
// Rate: one pixel leaves the unpacker per cycle while the output is not stalled, bounded
// by the single palette read port. A byte yields one pixel at 8 bits per pixel, two at
// 4 bits and up to eight at 1 bit (fewer at the end of a row). A byte request passes the
// unpacker byte slot, the palette read stage and the output register before its first
// pixel shows on the output. Reset (synchronous, active low) clears counters and all
// valids; the palette is undefined until written. Stalls back up through the output
// register and the palette read stage to o_in_stall.
module bmp_pixel_row_unpacker #(
    parameter int MAX_DIMENSION   = bpu_pkg::MAX_DIMENSION_DEFAULT,
    parameter int PALETTE_ENTRIES = bpu_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [bpu_pkg::COLOR_W-1:0]     i_data_byte,
    input  logic [bpu_pkg::COLOR_W-1:0]     i_palette_index,
    input  logic [bpu_pkg::COLOR_W-1:0]     i_palette_red,
    input  logic [bpu_pkg::COLOR_W-1:0]     i_palette_green,
    input  logic [bpu_pkg::COLOR_W-1:0]     i_palette_blue,
    // pixel channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bpu_pkg::COORD_W-1:0]     o_pixel_column,
    output logic [bpu_pkg::COORD_W-1:0]     o_pixel_row,
    output logic [bpu_pkg::COLOR_W-1:0]     o_red,
    output logic [bpu_pkg::COLOR_W-1:0]     o_green,
    output logic [bpu_pkg::COLOR_W-1:0]     o_blue,
    output logic                            o_visible,
    output logic                            o_last_of_run,
    output logic                            o_image_end
);

    import bpu_pkg::*;

`include "bmp_pixel_row_unpacker_macros.svh"

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]             r_pixel_format;
    logic [CFG_DIM_W-1:0]   r_image_width;
    logic [CFG_DIM_W-1:0]   r_image_height;
    logic [CFG_DIM_W-1:0]   r_clip_width;
    logic [CFG_DIM_W-1:0]   r_clip_height;
    logic [PAL_COUNT_W-1:0] r_palette_count;

    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format  <= FMT_1BPP;
            r_image_width   <= IMAGE_DIM_RESET;
            r_image_height  <= IMAGE_DIM_RESET;
            r_clip_width    <= CLIP_DIM_RESET;
            r_clip_height   <= CLIP_DIM_RESET;
            r_palette_count <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_PIXEL_FORMAT:  r_pixel_format  <= pwdata[1:0];
                REG_IMAGE_WIDTH:   r_image_width   <= pwdata[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_image_height  <= pwdata[CFG_DIM_W-1:0];
                REG_CLIP_WIDTH:    r_clip_width    <= pwdata[CFG_DIM_W-1:0];
                REG_CLIP_HEIGHT:   r_clip_height   <= pwdata[CFG_DIM_W-1:0];
                REG_PALETTE_COUNT: r_palette_count <= pwdata[PAL_COUNT_W-1:0];
                default: ;   // unmapped addresses: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PIXEL_FORMAT:  prdata = APB_DATA_W'(r_pixel_format);
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(r_image_height);
            REG_CLIP_WIDTH:    prdata = APB_DATA_W'(r_clip_width);
            REG_CLIP_HEIGHT:   prdata = APB_DATA_W'(r_clip_height);
            REG_PALETTE_COUNT: prdata = APB_DATA_W'(r_palette_count);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Row geometry, registered from the configuration. The user must write registers
    // only while idle (not enforced by the block), so these settle before the next byte.
    // ------------------------------------------------------------------
    logic [CFG_DIM_W-1:0]   r_width;
    logic [CFG_DIM_W-1:0]   r_height;
    logic [ROW_BYTES_W-1:0] r_data_bytes;   // bytes that carry pixels
    logic [ROW_BYTES_W-1:0] r_line_bytes;   // padded row length
    logic [CFG_DIM_W-1:0]   width_c;
    logic [ROW_BITS_W-1:0]  row_bits;
    logic [ROW_BITS_W-1:0]  row_bits_words;
    logic [ROW_BITS_W-1:0]  row_bits_bytes;

    always_comb begin
        width_c = clamp_dim(r_image_width, MAX_DIMENSION);
        unique case (r_pixel_format)
            FMT_1BPP:  row_bits = ROW_BITS_W'(width_c);
            FMT_4BPP:  row_bits = ROW_BITS_W'(width_c) << 2;
            FMT_8BPP:  row_bits = ROW_BITS_W'(width_c) << 3;
            FMT_24BPP: row_bits = (ROW_BITS_W'(width_c) << 4) + (ROW_BITS_W'(width_c) << 3);
        endcase
        row_bits_words = row_bits + ROW_BITS_W'(31);
        row_bits_bytes = row_bits + ROW_BITS_W'(7);
    end

    always_ff @(posedge i_clk) begin
        r_width      <= width_c;
        r_height     <= clamp_dim(r_image_height, MAX_DIMENSION);
        r_data_bytes <= row_bits_bytes[ROW_BITS_W-1:3];
        r_line_bytes <= {row_bits_words[ROW_BITS_W-1:5], 2'b00};
    end

    // ------------------------------------------------------------------
    // Pipeline handshakes
    // ------------------------------------------------------------------
    logic       r_alive;      // low during reset: refuse requests
    logic       r_s0_valid;   // byte held in the unpacker
    logic [7:0] r_s0_byte;
    logic [2:0] r_s0_slot;    // pixel within the byte
    logic       r_s1_valid;   // pixel waiting on the palette read
    t_pix_meta  r_s1;
    logic       r_out_valid;

    logic       out_free;
    logic       out_load;
    logic       s1_ready;
    logic       s0_free;
    logic       in_accept;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = r_s1_valid && out_free;
    assign s1_ready  = !r_s1_valid || out_load;
    assign in_accept = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Row state
    // ------------------------------------------------------------------
    logic [CFG_DIM_W-1:0]   r_col,   n_col;
    logic [CFG_DIM_W-1:0]   r_row,   n_row;
    logic [ROW_BYTES_W-1:0] r_rbc,   n_rbc;
    logic [1:0]             r_phase, n_phase;
    logic [15:0]            r_partial, n_partial;   // green high byte, blue low

    // ------------------------------------------------------------------
    // Unpacker: one pixel per cycle while the palette read stage can take it, from the held byte
    // ------------------------------------------------------------------
    logic                   is24;
    logic                   in_data;
    logic                   col_ok;
    logic                   col_last;
    logic [7:0]             s0_index;
    logic                   s0_last_slot;
    logic                   emit;
    logic                   step_ok;
    logic                   byte_done;
    logic [CFG_DIM_W-1:0]   flipped;
    logic [ROW_BYTES_W-1:0] rbc_inc;
    logic [CFG_DIM_W-1:0]   row_inc;
    logic                   from_pal;
    logic                   idx_oob;
    logic [PAL_AW-1:0]      ram_raddr;
    logic                   ram_re;
    t_pix_meta              s0_meta;

    assign is24     = (r_pixel_format == FMT_24BPP);
    assign in_data  = (r_rbc < r_data_bytes);
    assign col_ok   = (r_col < r_width);
    assign col_last = ((CFG_DIM_W+1)'(r_col) + 1'b1 == (CFG_DIM_W+1)'(r_width));
    assign flipped  = r_height - r_row - CFG_DIM_W'(1);
    assign rbc_inc  = r_rbc + ROW_BYTES_W'(1);
    assign row_inc  = r_row + CFG_DIM_W'(1);

    // Pick the index bits of this slot, most significant first.
    always_comb begin
        unique case (r_pixel_format)
            FMT_1BPP: begin
                s0_index     = {7'd0, r_s0_byte[3'd7 - r_s0_slot]};
                s0_last_slot = (r_s0_slot == 3'd7);
            end
            FMT_4BPP: begin
                s0_index     = r_s0_slot[0] ? {4'd0, r_s0_byte[3:0]} : {4'd0, r_s0_byte[7:4]};
                s0_last_slot = r_s0_slot[0];
            end
            FMT_8BPP: begin
                s0_index     = r_s0_byte;
                s0_last_slot = 1'b1;
            end
            FMT_24BPP: begin
                s0_index     = r_s0_byte;
                s0_last_slot = 1'b1;
            end
        endcase
    end

    // A 24-bit pixel completes on its red byte; indexed bytes emit while columns remain.
    assign emit      = r_s0_valid && in_data && col_ok && (!is24 || (r_phase == 2'd2));
    assign step_ok   = !emit || s1_ready;
    assign byte_done = r_s0_valid && step_ok &&
                       (!in_data || is24 || !col_ok || s0_last_slot || col_last);
    assign s0_free   = !r_s0_valid || byte_done;
    assign o_in_stall = !r_alive || !s0_free;

    // Out-of-range indexes read entry 0.
    assign from_pal  = !is24 && (r_palette_count != '0);
    assign idx_oob   = ({1'b0, s0_index} >= r_palette_count) ||
                       (32'(s0_index) >= PALETTE_ENTRIES);
    assign ram_raddr = idx_oob ? '0 : s0_index[PAL_AW-1:0];
    assign ram_re    = emit && step_ok && from_pal;

    always_comb begin
        s0_meta.column       = r_col[COORD_W-1:0];
        s0_meta.row          = flipped[COORD_W-1:0];
        s0_meta.rgb          = is24 ? {r_s0_byte, r_partial} : {s0_index, s0_index, s0_index};
        s0_meta.from_palette = from_pal;
        s0_meta.visible      = (r_row < r_height) && (r_col < r_clip_width) &&
                               (flipped < r_clip_height);
        s0_meta.last_of_run  = is24 || s0_last_slot || col_last;
        s0_meta.image_end    = col_last && (row_inc == r_height);
    end

    // Advance the row counters; the end of a padded row restarts the columns.
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_rbc     = r_rbc;
        n_phase   = r_phase;
        n_partial = r_partial;
        if (r_s0_valid && step_ok) begin
            if (emit) begin
                n_col = r_col + CFG_DIM_W'(1);
            end
            if (is24 && in_data) begin
                unique case (r_phase)
                    2'd0: begin
                        n_partial = {8'd0, r_s0_byte};
                        n_phase   = 2'd1;
                    end
                    2'd1: begin
                        n_partial = {r_s0_byte, r_partial[7:0]};
                        n_phase   = 2'd2;
                    end
                    default: n_phase = 2'd0;
                endcase
            end
            if (byte_done) begin
                n_rbc = rbc_inc;
                if (rbc_inc >= r_line_bytes) begin
                    n_rbc     = '0;
                    n_col     = '0;
                    n_phase   = 2'd0;
                    n_partial = '0;
                    n_row     = (row_inc >= r_height) ? '0 : row_inc;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Palette RAM: writes land only when the unpacker holds no byte or takes its last
    // read, so a same-entry collision reads the old value, as ordered.
    // ------------------------------------------------------------------
    logic              pal_we;
    logic [RGB_W-1:0]  ram_rdata;

    assign pal_we = in_accept && (i_operation == OP_PALETTE) &&
                    (32'(i_palette_index) < PALETTE_ENTRIES);

    bpu_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_palette_index[PAL_AW-1:0]),
        .i_wdata ({i_palette_red, i_palette_green, i_palette_blue}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequential control
    // ------------------------------------------------------------------
    t_pix_meta r_out;
    t_pix_meta out_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= 1'b0;
            r_s0_valid  <= 1'b0;
            r_s0_slot   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_rbc       <= '0;
            r_phase     <= 2'd0;
            r_partial   <= '0;
        end else begin
            r_alive   <= 1'b1;
            r_col     <= n_col;
            r_row     <= n_row;
            r_rbc     <= n_rbc;
            r_phase   <= n_phase;
            r_partial <= n_partial;

            // unpacker byte slot
            if (in_accept && (i_operation == OP_PIXEL)) begin
                r_s0_valid <= 1'b1;
                r_s0_slot  <= '0;
            end else if (byte_done) begin
                r_s0_valid <= 1'b0;
            end else if (emit && step_ok) begin
                r_s0_slot <= r_s0_slot + 3'd1;
            end

            // palette read stage
            if (emit && step_ok) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end

            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // take the palette entry in place of the raw color
    always_comb begin
        out_next = r_s1;
        if (r_s1.from_palette) begin
            out_next.rgb = ram_rdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept && (i_operation == OP_PIXEL)) begin
            r_s0_byte <= i_data_byte;
        end
        if (emit && step_ok) begin
            r_s1 <= s0_meta;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_column = r_out.column;
    assign o_pixel_row    = r_out.row;
    assign o_red          = r_out.rgb[RGB_W-1 -: COLOR_W];
    assign o_green        = r_out.rgb[2*COLOR_W-1 -: COLOR_W];
    assign o_blue         = r_out.rgb[COLOR_W-1:0];
    assign o_visible      = r_out.visible;
    assign o_last_of_run  = r_out.last_of_run;
    assign o_image_end    = r_out.image_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BPU_ASSERT_IMPLY(a_end_closes_run, i_clk, i_rst_n, o_out_valid && o_image_end, o_last_of_run)
    `BPU_ASSERT_IMPLY(a_read_needs_slot, i_clk, i_rst_n, ram_re, s1_ready)
    `BPU_ASSERT_NEXT(a_held_read_stable, i_clk, i_rst_n, r_s1_valid && !out_load, $stable(ram_rdata))
    `BPU_ASSERT_IMPLY(a_idle_takes_req, i_clk, i_rst_n, r_alive && !r_s0_valid, !o_in_stall)

endmodule
